/* design/assert_macros.svh */
// Assertion helpers; clk and rst come from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RWCP_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rwcp: assertion failed");

`define RWCP_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rwcp: assertion failed");

`endif

/* design/rwcp_pkg.sv */
package rwcp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [3:0] ERR_SHORT     = 4'd0;
  localparam logic [3:0] ERR_RIFF      = 4'd1;
  localparam logic [3:0] ERR_WAVE      = 4'd2;
  localparam logic [3:0] ERR_OVERRUN   = 4'd3;
  localparam logic [3:0] ERR_SMALL_FMT = 4'd4;
  localparam logic [3:0] ERR_FORMAT    = 4'd5;
  localparam logic [3:0] ERR_DATA      = 4'd6;
  localparam logic [3:0] ERR_PAD       = 4'd7;
  localparam logic [3:0] ERR_NO_DATA   = 4'd8;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  data_byte;
    logic        last_data;
    logic [3:0]  error_code;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] bytes_per_second;
    logic [15:0] frame_align;
    logic [15:0] sample_bits;
  } res_t;

endpackage

/* design/rwcp_if.sv */
interface rwcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first_byte;

  modport source (output valid, output file_byte, output first_byte, input ready);
  modport sink (input valid, input file_byte, input first_byte, output ready);
endinterface

interface rwcp_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  data_byte;
  logic        last_data;
  logic [3:0]  error_code;
  logic [15:0] format_tag;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] bytes_per_second;
  logic [15:0] frame_align;
  logic [15:0] sample_bits;

  modport source (output valid, output out_kind, output data_byte, output last_data,
                  output error_code, output format_tag, output channel_count,
                  output sample_rate, output bytes_per_second, output frame_align,
                  output sample_bits, input ready);
  modport sink (input valid, input out_kind, input data_byte, input last_data,
                input error_code, input format_tag, input channel_count,
                input sample_rate, input bytes_per_second, input frame_align,
                input sample_bits, output ready);
endinterface

interface rwcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_length;

  modport source (output valid, output file_length, input ready);
  modport sink (input valid, input file_length, output ready);
endinterface

/* design/rwcp_core.sv */
module rwcp_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      file_byte,
  input  logic            first_byte,
  input  logic [31:0]     file_length,
  output logic            res_valid,
  output rwcp_pkg::res_t  res
);
  import rwcp_pkg::*;

  localparam logic [2:0] PH_RIFF   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_FMT    = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_FAIL   = 3'd6;

  logic [2:0]  parse_phase, parse_phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [63:0] header_shift, header_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic        format_seen, format_seen_next;
  logic [63:0] fmt_fields, fmt_fields_next;
  logic [63:0] fmt_shift, fmt_shift_next;

  // state as seen by this byte (a first-byte mark restarts the parse)
  logic [2:0]  ph;
  logic [31:0] pos;
  logic [63:0] hs;
  logic [31:0] bl;
  logic        fs;
  logic        active;

  logic [33:0] np;
  logic [33:0] fl;
  logic [63:0] hs_shift;
  logic [31:0] id;
  logic [31:0] size;
  logic [31:0] bl_dec;
  logic        cnt_last;
  logic [3:0]  off;
  logic [32:0] rest;
  logic [33:0] pend;
  logic        hdr_room;
  logic        fmt_ok;

  assign ph     = first_byte ? PH_RIFF : parse_phase;
  assign pos    = first_byte ? 32'd0 : byte_position;
  assign hs     = first_byte ? 64'd0 : header_shift;
  assign bl     = first_byte ? 32'd0 : bytes_left;
  assign fs     = first_byte ? 1'b0 : format_seen;
  assign active = (ph <= PH_DATA);

  assign np       = {2'b00, pos} + 34'd1;
  assign fl       = {2'b00, file_length};
  assign hs_shift = {hs[55:0], file_byte};
  assign id       = hs_shift[63:32];
  assign size     = {hs_shift[7:0], hs_shift[15:8], hs_shift[23:16], hs_shift[31:24]};
  assign bl_dec   = (bl == 32'd0) ? 32'd0 : bl - 32'd1;
  assign cnt_last = (bl_dec == 32'd0);
  assign off      = 4'(4'd0 - bl[3:0]);
  assign hdr_room = !((np + 34'd8) > fl);

  // remaining body plus pad: unknown chunk from the header, fmt after its 16 bytes
  always_comb begin
    if (ph == PH_HEADER) begin
      rest = {1'b0, size} + {32'd0, size[0]};
    end else begin
      rest = {1'b0, chunk_length} - 33'd16 + {32'd0, chunk_length[0]};
    end
  end
  assign pend = np + {1'b0, rest};

  always_comb begin
    fmt_fields_next = fmt_fields;
    fmt_shift_next  = fmt_shift;
    for (int i = 0; i < 8; i++) begin
      if (off == 4'(i)) fmt_fields_next[8*i +: 8] = file_byte;
      if (off == 4'(i + 8)) fmt_shift_next[8*i +: 8] = file_byte;
    end
  end

  assign fmt_ok = (fmt_fields_next[15:0] == FMT_PCM || fmt_fields_next[15:0] == FMT_FLOAT)
                  && fmt_fields_next[31:16] != 16'd0 && fmt_fields_next[63:32] != 32'd0
                  && fmt_shift_next[31:0] != 32'd0 && fmt_shift_next[47:32] != 16'd0
                  && fmt_shift_next[63:48] != 16'd0;

  always_comb begin
    parse_phase_next   = ph;
    byte_position_next = active ? pos + 32'd1 : pos;
    header_shift_next  = hs;
    chunk_length_next  = chunk_length;
    bytes_left_next    = bl;
    format_seen_next   = fs;
    res_valid          = 1'b0;
    res                = '0;

    unique case (ph)
      PH_RIFF: begin
        header_shift_next = hs_shift;
        if (pos == 32'd0 && file_length < 32'd12) begin
          res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_SHORT;
        end else if (pos == 32'd3 && hs_shift[31:0] != TAG_RIFF) begin
          res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_RIFF;
        end else if (pos == 32'd11) begin
          if (hs_shift[31:0] != TAG_WAVE) begin
            res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_WAVE;
          end else if (!hdr_room) begin
            res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_NO_DATA;
          end else begin
            parse_phase_next = PH_HEADER; bytes_left_next = 32'd8; header_shift_next = '0;
          end
        end
      end
      PH_HEADER: begin
        header_shift_next = hs_shift;
        bytes_left_next   = bl_dec;
        if (cnt_last) begin
          chunk_length_next = size;
          if ((np + {2'b00, size}) > fl) begin
            res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_OVERRUN;
          end else if (id == TAG_FMT) begin
            if (size < 32'd16) begin
              res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_SMALL_FMT;
            end else begin
              bytes_left_next = 32'd16; parse_phase_next = PH_FMT;
            end
          end else if (id == TAG_DATA) begin
            if (!fs || size == 32'd0) begin
              res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_DATA;
            end else begin
              bytes_left_next = size; parse_phase_next = PH_DATA;
            end
          end else if (pend > fl) begin
            res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_PAD;
          end else if (rest == 33'd0) begin
            if (!hdr_room) begin
              res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_NO_DATA;
            end else begin
              parse_phase_next = PH_HEADER; bytes_left_next = 32'd8; header_shift_next = '0;
            end
          end else begin
            bytes_left_next = rest[31:0]; parse_phase_next = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        bytes_left_next = bl_dec;
        if (cnt_last) begin
          if (!fmt_ok) begin
            res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_FORMAT;
          end else begin
            format_seen_next = 1'b1;
            if (pend > fl) begin
              res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_PAD;
            end else if (rest == 33'd0) begin
              if (!hdr_room) begin
                res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_NO_DATA;
              end else begin
                parse_phase_next = PH_HEADER; bytes_left_next = 32'd8;
                header_shift_next = '0;
              end
            end else begin
              bytes_left_next = rest[31:0]; parse_phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        bytes_left_next = bl_dec;
        if (cnt_last) begin
          if (!hdr_room) begin
            res_valid = 1'b1; res.out_kind = KIND_ERROR; res.error_code = ERR_NO_DATA;
          end else begin
            parse_phase_next = PH_HEADER; bytes_left_next = 32'd8; header_shift_next = '0;
          end
        end
      end
      PH_DATA: begin
        res_valid              = 1'b1;
        res.out_kind           = KIND_DATA;
        res.data_byte          = file_byte;
        res.last_data          = cnt_last;
        res.format_tag         = fmt_fields[15:0];
        res.channel_count      = fmt_fields[31:16];
        res.sample_rate        = fmt_fields[63:32];
        res.bytes_per_second   = fmt_shift[31:0];
        res.frame_align        = fmt_shift[47:32];
        res.sample_bits        = fmt_shift[63:48];
        bytes_left_next        = bl_dec;
        if (cnt_last) parse_phase_next = PH_DONE;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase

    if (res_valid && res.out_kind == KIND_ERROR) parse_phase_next = PH_FAIL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_RIFF;
      byte_position <= '0;
      header_shift  <= '0;
      chunk_length  <= '0;
      bytes_left    <= '0;
      format_seen   <= 1'b0;
    end else if (step) begin
      parse_phase   <= parse_phase_next;
      byte_position <= byte_position_next;
      header_shift  <= header_shift_next;
      chunk_length  <= chunk_length_next;
      bytes_left    <= bytes_left_next;
      format_seen   <= format_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ph == PH_FMT) begin
      fmt_fields <= fmt_fields_next;
      fmt_shift  <= fmt_shift_next;
    end
  end

endmodule

/* design/riff_wave_chunk_parser_top.sv */
// A result is registered and appears on report in the cycle after its byte is accepted.
// Throughput: one byte per cycle; feed stalls only while a result waits on report.
// Reset (rst, synchronous): parser restarts at the RIFF header, file_length clears to 0,
// the result register empties. Bytes are parsed as a new file even without a mark.
`include "assert_macros.svh"

module riff_wave_chunk_parser_top (
  input  logic        clk,
  input  logic        rst,
  rwcp_cfg_if.sink    cfg,
  rwcp_in_if.sink     feed,
  rwcp_out_if.source  report
);
  import rwcp_pkg::*;

  logic [31:0] file_length;
  logic        step;
  logic        core_valid;
  res_t        core_res;
  logic        out_valid;
  res_t        out_res;

  assign cfg.ready   = 1'b1;
  assign feed.ready  = !out_valid || report.ready;
  assign step        = feed.valid && feed.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
    end else if (cfg.valid && cfg.ready) begin
      file_length <= cfg.file_length;
    end
  end

  rwcp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .file_byte   (feed.file_byte),
    .first_byte  (feed.first_byte),
    .file_length (file_length),
    .res_valid   (core_valid),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && core_valid) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_valid) out_res <= core_res;
  end

  assign report.valid            = out_valid;
  assign report.out_kind         = out_res.out_kind;
  assign report.data_byte        = out_res.data_byte;
  assign report.last_data        = out_res.last_data;
  assign report.error_code       = out_res.error_code;
  assign report.format_tag       = out_res.format_tag;
  assign report.channel_count    = out_res.channel_count;
  assign report.sample_rate      = out_res.sample_rate;
  assign report.bytes_per_second = out_res.bytes_per_second;
  assign report.frame_align      = out_res.frame_align;
  assign report.sample_bits      = out_res.sample_bits;

  `RWCP_ASSERT_NXT(a_result_loaded, step && core_valid, out_valid)
  `RWCP_ASSERT_IMP(a_stall_only_when_full, !feed.ready, out_valid && !report.ready)
  `RWCP_ASSERT_IMP(a_data_has_format,
    out_valid && out_res.out_kind == KIND_DATA,
    (out_res.format_tag == FMT_PCM || out_res.format_tag == FMT_FLOAT) &&
    out_res.sample_rate != 32'd0 && out_res.error_code == ERR_SHORT)

endmodule
